[rtl/core/jdam_pkg.sv]
package jdam_pkg;

   // Width of a millivolt reading and of every calibration register.
   localparam int VOLT_BITS = 12;

   // Full-scale deflection and the quotient width that holds it.
   localparam int SCALE = 100;
   localparam int QUO_W = $clog2(SCALE + 1);

   // Width of the scaled numerator (offset times full scale).
   localparam int NUM_W = VOLT_BITS + QUO_W;

   localparam int POS_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W = 3;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_X_CENTRE_LOW  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_X_CENTRE_HIGH = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_X_MIN         = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_X_MAX         = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_Y_CENTRE_LOW  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_Y_CENTRE_HIGH = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_Y_MIN         = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_Y_MAX         = 3'd7;

   localparam logic [VOLT_BITS-1:0] RESET_MAX = VOLT_BITS'(3300);

   // Axis codes.
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   // Calibration of one axis.
   typedef struct packed {
      logic [VOLT_BITS-1:0] centre_low;
      logic [VOLT_BITS-1:0] centre_high;
      logic [VOLT_BITS-1:0] vmin;
      logic [VOLT_BITS-1:0] vmax;
   } cal_type;

   // One word in flight through the divider stages.
   typedef struct packed {
      logic                 axis;
      logic                 neg;
      logic                 err;
      logic [NUM_W-1:0]     rem;
      logic [VOLT_BITS-1:0] div;
      logic [QUO_W-1:0]     quo;
   } div_type;

endpackage

[rtl/core/joystick_deadzone_axis_mapper_unit.sv]
// Joystick dead-zone axis mapper. Each request word carries a millivolt reading and an axis
// select (0 for X, 1 for Y); each response word carries the axis, a signed deflection in
// -100..100 and a span error flag. Readings at or above the axis's centre_high are clipped to
// [centre_high, max] and scaled onto 0..100, readings at or below centre_low are clipped to
// [min, centre_low] and scaled onto -100..0, and readings in between give 0. The positive range
// wins when both apply. A zero-width span gives 0 with span_error set; an inverted span gives
// the branch's end value. The block accepts one word per clock cycle while req_stall is low.
// A word passes through QUO_W + 4 register stages (11 at the default width): one input stage,
// one clip stage, one constant-multiply stage, one restoring-divider stage per quotient bit, and
// the output stage. A response stall reaches back in the same cycle only through stages that
// are full, and empty stages keep filling, so a waiting response does not block new requests
// until the pipeline is full. Calibration registers sit on the APB-style port at byte address
// 4*index and should be written only while no word is in flight.
module joystick_deadzone_axis_mapper_unit
   import jdam_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_axis,
   input  logic [VOLT_BITS-1:0]         req_millivolts,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_axis_out,
   output logic signed [POS_W-1:0]      rsp_position,
   output logic                         rsp_span_error,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   // Stage numbering: input, clip, multiply, one per quotient bit, then output.
   localparam int ST_IN   = 0;
   localparam int ST_CLIP = 1;
   localparam int ST_MUL  = 2;
   localparam int ST_OUT  = ST_MUL + QUO_W + 1;

   // ------------------------------------------------------------------
   // Calibration registers
   // ------------------------------------------------------------------
   cal_type x_cal_ff, x_cal_in;
   cal_type y_cal_ff, y_cal_in;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;
   logic [VOLT_BITS-1:0] csr_wval;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wval   = csr_pwdata[VOLT_BITS-1:0];

   always_comb begin
      x_cal_in = x_cal_ff;
      y_cal_in = y_cal_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_X_CENTRE_LOW:  x_cal_in.centre_low  = csr_wval;
            REG_X_CENTRE_HIGH: x_cal_in.centre_high = csr_wval;
            REG_X_MIN:         x_cal_in.vmin        = csr_wval;
            REG_X_MAX:         x_cal_in.vmax        = csr_wval;
            REG_Y_CENTRE_LOW:  y_cal_in.centre_low  = csr_wval;
            REG_Y_CENTRE_HIGH: y_cal_in.centre_high = csr_wval;
            REG_Y_MIN:         y_cal_in.vmin        = csr_wval;
            REG_Y_MAX:         y_cal_in.vmax        = csr_wval;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_cal_ff <= '{centre_low: '0, centre_high: '0, vmin: '0, vmax: RESET_MAX};
         y_cal_ff <= '{centre_low: '0, centre_high: '0, vmin: '0, vmax: RESET_MAX};
      end else begin
         x_cal_ff <= x_cal_in;
         y_cal_ff <= y_cal_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_X_CENTRE_LOW:  csr_prdata = CSR_DATA_W'(x_cal_ff.centre_low);
         REG_X_CENTRE_HIGH: csr_prdata = CSR_DATA_W'(x_cal_ff.centre_high);
         REG_X_MIN:         csr_prdata = CSR_DATA_W'(x_cal_ff.vmin);
         REG_X_MAX:         csr_prdata = CSR_DATA_W'(x_cal_ff.vmax);
         REG_Y_CENTRE_LOW:  csr_prdata = CSR_DATA_W'(y_cal_ff.centre_low);
         REG_Y_CENTRE_HIGH: csr_prdata = CSR_DATA_W'(y_cal_ff.centre_high);
         REG_Y_MIN:         csr_prdata = CSR_DATA_W'(y_cal_ff.vmin);
         REG_Y_MAX:         csr_prdata = CSR_DATA_W'(y_cal_ff.vmax);
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Flow control. A stage may load when it is empty or when the stage
   // after it loads in the same cycle.
   // ------------------------------------------------------------------
   logic [ST_OUT:0] vld_ff;
   logic [ST_OUT:0] vld_in;
   logic [ST_OUT:0] rdy;

   always_comb begin
      rdy[ST_OUT] = !vld_ff[ST_OUT] || !rsp_stall;
      for (int i = ST_OUT - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (rdy[ST_IN]) vld_in[ST_IN] = req_valid;
      for (int i = 1; i <= ST_OUT; i++) begin
         if (rdy[i]) vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !rdy[ST_IN];

   // ------------------------------------------------------------------
   // Input stage
   // ------------------------------------------------------------------
   logic                 in_axis_ff;
   logic [VOLT_BITS-1:0] in_mv_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_IN]) begin
         in_axis_ff <= req_axis;
         in_mv_ff   <= req_millivolts;
      end
   end

   // ------------------------------------------------------------------
   // Clip stage: pick the branch and its bounds, clip the reading and
   // form offset and span. Special cases are folded into offset/span so
   // the divider needs no extra flags: the dead zone and a zero span
   // divide 0 by 1, an inverted span divides 1 by 1 (full end value).
   // ------------------------------------------------------------------
   cal_type              cal;
   logic                 pos_br;
   logic                 neg_br;
   logic [VOLT_BITS-1:0] lo;
   logic [VOLT_BITS-1:0] hi;
   logic [VOLT_BITS-1:0] v_up;
   logic [VOLT_BITS-1:0] v_clip;

   logic                 clip_axis_ff, clip_axis_in;
   logic                 clip_neg_ff,  clip_neg_in;
   logic                 clip_err_ff,  clip_err_in;
   logic [VOLT_BITS-1:0] clip_off_ff,  clip_off_in;
   logic [VOLT_BITS-1:0] clip_span_ff, clip_span_in;

   always_comb begin
      cal    = (in_axis_ff == AXIS_Y) ? y_cal_ff : x_cal_ff;
      pos_br = in_mv_ff >= cal.centre_high;
      neg_br = !pos_br && (in_mv_ff <= cal.centre_low);
      lo     = pos_br ? cal.centre_high : cal.vmin;
      hi     = pos_br ? cal.vmax : cal.centre_low;
      v_up   = (in_mv_ff < lo) ? lo : in_mv_ff;
      v_clip = (v_up > hi) ? hi : v_up;

      clip_axis_in = in_axis_ff;
      clip_neg_in  = 1'b0;
      clip_err_in  = 1'b0;
      clip_off_in  = '0;
      clip_span_in = VOLT_BITS'(1);
      if (pos_br || neg_br) begin
         if (hi == lo) begin
            clip_err_in = 1'b1;
         end else if (hi < lo) begin
            clip_neg_in = neg_br;
            clip_off_in = VOLT_BITS'(1);
         end else begin
            clip_neg_in  = neg_br;
            clip_off_in  = v_clip - lo;
            clip_span_in = hi - lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_CLIP]) begin
         clip_axis_ff <= clip_axis_in;
         clip_neg_ff  <= clip_neg_in;
         clip_err_ff  <= clip_err_in;
         clip_off_ff  <= clip_off_in;
         clip_span_ff <= clip_span_in;
      end
   end

   // ------------------------------------------------------------------
   // Multiply stage and restoring divider. Entry 0 holds the scaled
   // numerator; entry k has resolved quotient bit QUO_W-k. The offset
   // never exceeds the span, so the quotient stays within full scale.
   // ------------------------------------------------------------------
   div_type div_ff [QUO_W+1];
   div_type div_in [QUO_W+1];

   always_comb begin
      div_in[0].axis = clip_axis_ff;
      div_in[0].neg  = clip_neg_ff;
      div_in[0].err  = clip_err_ff;
      div_in[0].rem  = NUM_W'(clip_off_ff) * NUM_W'(SCALE);
      div_in[0].div  = clip_span_ff;
      div_in[0].quo  = '0;
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_div
      localparam int BIT = QUO_W - k;
      logic [NUM_W-1:0] trial;

      always_comb begin
         trial     = NUM_W'(div_ff[k-1].div) << BIT;
         div_in[k] = div_ff[k-1];
         if (div_ff[k-1].rem >= trial) begin
            div_in[k].rem      = div_ff[k-1].rem - trial;
            div_in[k].quo[BIT] = 1'b1;
         end
      end
   end

   for (genvar k = 0; k <= QUO_W; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (rdy[ST_MUL + k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: the negative branch shifts the quotient down by full
   // scale.
   // ------------------------------------------------------------------
   logic signed [POS_W-1:0] quo_s;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic                    out_axis_ff;
   logic                    out_err_ff;

   always_comb begin
      quo_s  = signed'(POS_W'(div_ff[QUO_W].quo));
      pos_in = div_ff[QUO_W].neg ? quo_s - POS_W'(SCALE) : quo_s;
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_OUT]) begin
         pos_ff      <= pos_in;
         out_axis_ff <= div_ff[QUO_W].axis;
         out_err_ff  <= div_ff[QUO_W].err;
      end
   end

   assign rsp_valid      = vld_ff[ST_OUT];
   assign rsp_axis_out   = out_axis_ff;
   assign rsp_position   = pos_ff;
   assign rsp_span_error = out_err_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_error |-> rsp_position == 0)
      else $error("span error response with nonzero position");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position <= SCALE) && (rsp_position >= -SCALE))
      else $error("position out of range");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT-1] |-> div_ff[QUO_W].quo <= QUO_W'(SCALE))
      else $error("quotient above full scale");

   a_in_free: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[ST_IN] |-> !req_stall)
      else $error("request stalled with empty input stage");

   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_OUT-1] && !vld_ff[ST_OUT] |=> vld_ff[ST_OUT])
      else $error("word failed to move into empty output stage");

endmodule

[test/tb_joystick_deadzone_axis_mapper_unit.sv]
`timescale 1ns / 100ps

module tb_joystick_deadzone_axis_mapper_unit;
   import jdam_pkg::*;

   // Run shape. Extreme calibrations force every word into the error path, so those phases are
   // kept short; the rest carry the bulk of the random words.
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_WORDS     = 300;
   localparam int EXTREME_WORDS   = 60;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int DRAIN_SLACK     = 4 * (QUO_W + 4);
   localparam int CYCLE_LIMIT     = 200000;
   localparam int VOLT_TOP        = (1 << VOLT_BITS) - 1;

   // One response word as the pipeline should deliver it.
   typedef struct packed {
      logic                    axis;
      logic signed [POS_W-1:0] position;
      logic                    span_error;
   } deflection_type;

   // A directed row either carries its answer, or leaves it to the predictor.
   typedef enum bit {
      CHECK_PREDICTED,
      CHECK_TYPED
   } row_check_type;

   typedef struct {
      int            cal_set;
      logic          axis;
      int            mv;
      row_check_type check;
      int            pos;
      logic          err;
   } probe_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_axis = 1'b0;
   logic [VOLT_BITS-1:0]    req_millivolts = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_axis_out;
   logic signed [POS_W-1:0] rsp_position;
   logic                    rsp_span_error;

   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   joystick_deadzone_axis_mapper_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_axis       (req_axis),
      .req_millivolts (req_millivolts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_axis_out   (rsp_axis_out),
      .rsp_position   (rsp_position),
      .rsp_span_error (rsp_span_error),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #6 clock = ~clock;

   // Our own copy of the calibration registers, indexed by axis code. It follows every write
   // that the testbench makes, so it is always what the block should hold.
   cal_type        cal_model [2];

   // Deflections predicted for accepted request words, oldest first.
   deflection_type pending_deflections [$];

   int             mismatch_count = 0;
   int             csr_mismatch_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   logic           holding = 1'b0;
   event           holdoff_go;

   // Directed words. The calibration set changes only between groups of rows; set 0 is the
   // state straight out of reset and is never written.
   cal_type        probe_cals [5][2];
   probe_row_type  probe_rows [23] = '{
      // Reset calibration: the whole scale is the positive range 0..3300.
      '{0, AXIS_X,    0, CHECK_TYPED,       0, 1'b0},
      '{0, AXIS_X, 3300, CHECK_TYPED,     100, 1'b0},
      '{0, AXIS_Y, 4095, CHECK_TYPED,     100, 1'b0},
      '{0, AXIS_Y, 1650, CHECK_TYPED,      50, 1'b0},
      '{0, AXIS_X, 2047, CHECK_PREDICTED,   0, 1'b0},
      // Ordinary calibration: dead zone, clipping at both ends, the centre bounds.
      '{1, AXIS_X, 1650, CHECK_TYPED,       0, 1'b0},
      '{1, AXIS_X,    0, CHECK_TYPED,    -100, 1'b0},
      '{1, AXIS_X, 4095, CHECK_TYPED,     100, 1'b0},
      '{1, AXIS_X, 1500, CHECK_TYPED,       0, 1'b0},
      '{1, AXIS_X, 1000, CHECK_PREDICTED,   0, 1'b0},
      '{1, AXIS_Y,    0, CHECK_TYPED,    -100, 1'b0},
      '{1, AXIS_Y, 3000, CHECK_PREDICTED,   0, 1'b0},
      // X has zero-width spans on both sides, Y has both spans inverted.
      '{2, AXIS_X, 2500, CHECK_TYPED,       0, 1'b1},
      '{2, AXIS_X,  500, CHECK_TYPED,       0, 1'b1},
      '{2, AXIS_X, 1500, CHECK_TYPED,       0, 1'b0},
      '{2, AXIS_Y, 3500, CHECK_TYPED,     100, 1'b0},
      '{2, AXIS_Y,  500, CHECK_TYPED,       0, 1'b0},
      // X centre bounds crossed so both ranges overlap; Y registers all at full scale.
      '{3, AXIS_X, 2000, CHECK_PREDICTED,   0, 1'b0},
      '{3, AXIS_X,  500, CHECK_PREDICTED,   0, 1'b0},
      '{3, AXIS_Y, 4095, CHECK_TYPED,       0, 1'b1},
      '{3, AXIS_Y,    0, CHECK_TYPED,       0, 1'b1},
      // Every register zero: each reading lands in a zero-width positive span.
      '{4, AXIS_X,    0, CHECK_TYPED,       0, 1'b1},
      '{4, AXIS_Y, 4095, CHECK_TYPED,       0, 1'b1}
   };

   function automatic cal_type calib(int clo, int chi, int vmin, int vmax);
      cal_type c;
      c.centre_low  = VOLT_BITS'(clo);
      c.centre_high = VOLT_BITS'(chi);
      c.vmin        = VOLT_BITS'(vmin);
      c.vmax        = VOLT_BITS'(vmax);
      return c;
   endfunction

   // Mostly well-ordered calibrations with random content, so that all three regions are hit;
   // the rest collapse both spans to zero width or scatter the registers freely, which produces
   // inverted spans and overlapping centre bounds.
   function automatic cal_type random_calibration();
      int kind;
      int vmin;
      int clo;
      int chi;
      kind = $urandom_range(9);
      if (kind < 6) begin
         vmin = $urandom_range(1000);
         clo  = vmin + $urandom_range(1500);
         chi  = clo + $urandom_range(500);
         return calib(clo, chi, vmin, chi + $urandom_range(VOLT_TOP - chi));
      end else if (kind == 6) begin
         clo = $urandom_range(VOLT_TOP);
         chi = $urandom_range(VOLT_TOP);
         return calib(clo, chi, clo, chi);
      end
      return calib($urandom_range(VOLT_TOP), $urandom_range(VOLT_TOP),
                   $urandom_range(VOLT_TOP), $urandom_range(VOLT_TOP));
   endfunction

   // Expected response for one reading under the current calibration of its axis. The upper
   // range is tried first, then the lower one; a reading in neither is in the dead zone.
   // Clipping raises to the low bound before lowering to the high bound, which is what makes
   // an inverted span settle on its end value.
   function automatic deflection_type predict_deflection(logic axis,
                                                         logic [VOLT_BITS-1:0] mv);
      deflection_type w;
      cal_type        c;
      int             v;
      int             lo;
      int             hi;
      int             out_lo;
      int             out_hi;
      int             span;
      int             pos;
      bit             mapped;
      c = cal_model[axis];
      v = int'(mv);
      pos = 0;
      mapped = 1'b1;
      w.span_error = 1'b0;
      if (v >= int'(c.centre_high)) begin
         lo = int'(c.centre_high);
         hi = int'(c.vmax);
         out_lo = 0;
         out_hi = SCALE;
      end else if (v <= int'(c.centre_low)) begin
         lo = int'(c.vmin);
         hi = int'(c.centre_low);
         out_lo = -SCALE;
         out_hi = 0;
      end else begin
         mapped = 1'b0;
      end
      if (mapped) begin
         span = hi - lo;
         if (span == 0) begin
            w.span_error = 1'b1;
         end else begin
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            // SystemVerilog integer division truncates toward zero, as required.
            pos = (v - lo) * (out_hi - out_lo) / span + out_lo;
         end
      end
      w.axis = axis;
      w.position = POS_W'(pos);
      return w;
   endfunction

   // One APB transfer: a setup phase, then the access phase held until pready.
   task automatic csr_transfer(input bit is_write, input logic [REG_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write a register with junk in the unused upper bits, read it back, and mirror it.
   task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                 input logic [VOLT_BITS-1:0] value);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] rdata;
      wdata = $urandom();
      wdata[VOLT_BITS-1:0] = value;
      csr_transfer(1'b1, idx, wdata, rdata);
      csr_transfer(1'b0, idx, '0, rdata);
      if (rdata !== CSR_DATA_W'(value)) begin
         $display("%0t: register %0d read back: expected %0d, actual %0d",
                  $time, idx, value, rdata);
         csr_mismatch_count++;
      end
      case (idx)
         REG_X_CENTRE_LOW:  cal_model[AXIS_X].centre_low  = value;
         REG_X_CENTRE_HIGH: cal_model[AXIS_X].centre_high = value;
         REG_X_MIN:         cal_model[AXIS_X].vmin        = value;
         REG_X_MAX:         cal_model[AXIS_X].vmax        = value;
         REG_Y_CENTRE_LOW:  cal_model[AXIS_Y].centre_low  = value;
         REG_Y_CENTRE_HIGH: cal_model[AXIS_Y].centre_high = value;
         REG_Y_MIN:         cal_model[AXIS_Y].vmin        = value;
         REG_Y_MAX:         cal_model[AXIS_Y].vmax        = value;
         default: ;
      endcase
   endtask

   task automatic program_calibration(input cal_type xc, input cal_type yc);
      write_register(REG_X_CENTRE_LOW,  xc.centre_low);
      write_register(REG_X_CENTRE_HIGH, xc.centre_high);
      write_register(REG_X_MIN,         xc.vmin);
      write_register(REG_X_MAX,         xc.vmax);
      write_register(REG_Y_CENTRE_LOW,  yc.centre_low);
      write_register(REG_Y_CENTRE_HIGH, yc.centre_high);
      write_register(REG_Y_MIN,         yc.vmin);
      write_register(REG_Y_MAX,         yc.vmax);
   endtask

   // Offer one request word, with random idle cycles ahead of it, and hold it until the block
   // takes it. The prediction is queued at the edge that accepts the word; a response taken at
   // that same edge belongs to a much older word, so the queue stays in order.
   task automatic offer_reading(input logic axis, input logic [VOLT_BITS-1:0] mv,
                                input deflection_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_axis <= axis;
      req_millivolts <= mv;
      do @(posedge clock); while (req_stall);
      pending_deflections.push_back(want);
   endtask

   // Stop offering and wait until every accepted word has come back. Each word gives exactly
   // one response, so an empty queue means an empty pipeline.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_deflections.size() != 0) @(posedge clock);
   endtask

   // Receiver side: random stalls at the phase's rate, or a solid stall during the hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= holding || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // The long hold-off runs in its own process, counting cycles, while the sender keeps going.
   initial begin
      @(holdoff_go);
      holding <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   // Response checker: each accepted response word is matched against the oldest prediction.
   always @(posedge clock) begin
      deflection_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_deflections.size() == 0) begin
            $display("%0t: unexpected response word: axis %0d position %0d span_error %0d",
                     $time, rsp_axis_out, rsp_position, rsp_span_error);
            mismatch_count++;
         end else begin
            want = pending_deflections.pop_front();
            if (rsp_axis_out !== want.axis) begin
               $display("%0t: axis_out: expected %0d, actual %0d",
                        $time, want.axis, rsp_axis_out);
               mismatch_count++;
            end
            if (rsp_position !== want.position) begin
               $display("%0t: position: expected %0d, actual %0d",
                        $time, want.position, rsp_position);
               mismatch_count++;
            end
            if (rsp_span_error !== want.span_error) begin
               $display("%0t: span_error: expected %0d, actual %0d",
                        $time, want.span_error, rsp_span_error);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      deflection_type       want;
      probe_row_type        row;
      int                   active_set;
      int                   words;
      int                   pick;
      int                   bound;
      logic                 axis;
      logic [VOLT_BITS-1:0] mv;
      cal_type              c;
      cal_type              xc;
      cal_type              yc;

      cal_model[AXIS_X] = calib(0, 0, 0, int'(RESET_MAX));
      cal_model[AXIS_Y] = calib(0, 0, 0, int'(RESET_MAX));
      probe_cals[1][AXIS_X] = calib(1500, 1800, 200, 3100);
      probe_cals[1][AXIS_Y] = calib(2000, 2100, 0, VOLT_TOP);
      probe_cals[2][AXIS_X] = calib(1000, 2000, 1000, 2000);
      probe_cals[2][AXIS_Y] = calib(1000, 3000, 2000, 2500);
      probe_cals[3][AXIS_X] = calib(3000, 1000, 0, VOLT_TOP);
      probe_cals[3][AXIS_Y] = calib(VOLT_TOP, VOLT_TOP, VOLT_TOP, VOLT_TOP);
      probe_cals[4][AXIS_X] = calib(0, 0, 0, 0);
      probe_cals[4][AXIS_Y] = calib(0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from the reset calibration.
      active_set = 0;
      foreach (probe_rows[i]) begin
         row = probe_rows[i];
         if (row.cal_set != active_set) begin
            settle_pipeline();
            program_calibration(probe_cals[row.cal_set][AXIS_X],
                                probe_cals[row.cal_set][AXIS_Y]);
            active_set = row.cal_set;
         end
         if (row.check == CHECK_TYPED) begin
            want.axis = row.axis;
            want.position = POS_W'(row.pos);
            want.span_error = row.err;
         end else begin
            want = predict_deflection(row.axis, VOLT_BITS'(row.mv));
         end
         offer_reading(row.axis, VOLT_BITS'(row.mv), want);
      end

      // Random part. Each phase gets a fresh calibration and one of four idling patterns; two
      // phases use the register extremes.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_pipeline();
         words = PHASE_WORDS;
         case (phase)
            3: begin
               xc = calib(VOLT_TOP, VOLT_TOP, VOLT_TOP, VOLT_TOP);
               yc = xc;
               words = EXTREME_WORDS;
            end
            5: begin
               xc = calib(0, 0, 0, 0);
               yc = xc;
               words = EXTREME_WORDS;
            end
            default: begin
               xc = random_calibration();
               yc = random_calibration();
            end
         endcase
         program_calibration(xc, yc);

         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 75;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 75;
            end
            default: begin
               send_idle_pct = 19;
               recv_stall_pct = 19;
            end
         endcase

         // In the first phase the receiver holds off while the sender streams at full rate,
         // so the pipeline fills and the request side has to stall.
         if (phase == 0) begin
            -> holdoff_go;
         end

         for (int n = 0; n < words; n++) begin
            axis = 1'($urandom_range(1));
            c = cal_model[axis];
            pick = $urandom_range(99);
            if (pick < 10) begin
               mv = pick[0] ? '1 : '0;
            end else if (pick < 35) begin
               // Land on or right next to one of the axis's bounds.
               case ($urandom_range(3))
                  0: bound = int'(c.centre_low);
                  1: bound = int'(c.centre_high);
                  2: bound = int'(c.vmin);
                  default: bound = int'(c.vmax);
               endcase
               bound = bound + int'($urandom_range(4)) - 2;
               if (bound < 0) bound = 0;
               if (bound > VOLT_TOP) bound = VOLT_TOP;
               mv = VOLT_BITS'(bound);
            end else begin
               mv = VOLT_BITS'($urandom());
            end
            offer_reading(axis, mv, predict_deflection(axis, mv));
         end
      end

      settle_pipeline();
      repeat (DRAIN_SLACK) @(posedge clock);
      if (mismatch_count == 0 && csr_mismatch_count == 0 &&
          pending_deflections.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[joystick_deadzone_axis_mapper_unit.f]
rtl/core/jdam_pkg.sv
rtl/core/joystick_deadzone_axis_mapper_unit.sv
test/tb_joystick_deadzone_axis_mapper_unit.sv
